// ===== src/annexb_nal_unit_splitter_defines.svh =====
// assertion macros for the annex b nal unit splitter
// used by the top level only; expects clk and rst_n in scope
`ifndef ANNEXB_NAL_UNIT_SPLITTER_DEFINES_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NALSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nalsp check failed");

// next-cycle implication, checked outside reset
`define NALSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nalsp check failed");

`endif

// ===== src/nalsp_pkg.sv =====
// shared types, constants and helpers for the annex b nal unit splitter
// no dependencies
package nalsp_pkg;

  localparam int unsigned MAX_NALS = 5;

  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [3:0]  MAX_NALS_W = 4'(MAX_NALS);

  localparam logic [5:0] END_FIRST_RST  = 6'd19;
  localparam logic [5:0] END_SECOND_RST = 6'd1;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_END_FIRST  = 1'b0,
    CFG_END_SECOND = 1'b1
  } cfg_idx_t;

  // access unit closing types
  typedef struct packed {
    logic [5:0] first;
    logic [5:0] second;
  } end_types_t;

  // one finished nal record
  typedef struct packed {
    logic [5:0]  nal_type;
    logic [23:0] nal_length;
    logic [2:0]  nal_index;
    logic        unit_end;
    logic        index_overflow;
  } nal_rec_t;

  // scanner result for the beat being taken
  typedef struct packed {
    logic     emit;
    nal_rec_t rec;
  } scan_res_t;

  // saturating byte count increment
  function automatic logic [23:0] sat_inc(input logic [23:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 24'd1;
  endfunction

endpackage

// ===== src/nalsp_stream_if.sv =====
// valid/ready channel interfaces for byte input and nal records
// no dependencies
interface nalsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface nalsp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  nal_type;
  logic [23:0] nal_length;
  logic [2:0]  nal_index;
  logic        unit_end;
  logic        index_overflow;

  modport source (output valid, output nal_type, output nal_length, output nal_index,
                  output unit_end, output index_overflow, input ready);
  modport sink (input valid, input nal_type, input nal_length, input nal_index,
                input unit_end, input index_overflow, output ready);
endinterface

// ===== src/nalsp_cfg_regs.sv =====
// end-of-unit type registers written through the plain write port
// depends on nalsp_pkg
module nalsp_cfg_regs import nalsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  cfg_idx_t   cfg_index,
  input  logic [5:0] cfg_wdata,
  output end_types_t end_types
);

  end_types_t end_types_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_types_r.first  <= END_FIRST_RST;
      end_types_r.second <= END_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_END_FIRST:  end_types_r.first  <= cfg_wdata;
        CFG_END_SECOND: end_types_r.second <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign end_types = end_types_r;

endmodule

// ===== src/nalsp_scanner.sv =====
// start code matcher, nal byte counter and access unit index tracking
// depends on nalsp_pkg
module nalsp_scanner import nalsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  end_types_t end_types,
  output scan_res_t  res
);

  logic [23:0] hist_r, hist_nxt;
  logic [1:0]  hv_r, hv_nxt;
  logic        in_nal_r, in_nal_nxt;
  logic        hdr_r, hdr_nxt;
  logic [5:0]  type_r, type_nxt;
  logic [23:0] count_r, count_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        ovf_r, ovf_nxt;

  logic        start_hit;
  logic        four_byte;
  logic [23:0] zeros;
  logic        ends;
  logic [23:0] len;

  // pattern match on history and incoming beat
  assign start_hit = !hdr_r && (data_byte == BYTE_ONE) && (hv_r >= 2'd2) &&
                     (hist_r[15:0] == {BYTE_ZERO, BYTE_ZERO});
  assign four_byte = (hv_r == 2'd3) && (hist_r[23:16] == BYTE_ZERO);
  assign zeros     = four_byte ? 24'd3 : 24'd2;
  assign ends      = (type_r == end_types.first) || (type_r == end_types.second);

  // length of the closing nal without the zeros of the new start code
  always_comb begin
    if (count_r == COUNT_MAX)  len = COUNT_MAX;
    else if (count_r >= zeros) len = count_r - zeros;
    else                       len = '0;
  end

  // record for the nal that this start code closes
  always_comb begin
    res.emit               = start_hit && in_nal_r;
    res.rec.nal_type       = type_r;
    res.rec.nal_length     = len;
    res.rec.nal_index      = idx_r;
    res.rec.unit_end       = ends;
    res.rec.index_overflow = ovf_r;
  end

  // next state for one beat
  always_comb begin
    hist_nxt   = hist_r;
    hv_nxt     = hv_r;
    in_nal_nxt = in_nal_r;
    hdr_nxt    = hdr_r;
    type_nxt   = type_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    if (hdr_r) begin
      // header byte opens the nal
      type_nxt   = data_byte[6:1];
      count_nxt  = sat_inc(count_r);
      hdr_nxt    = 1'b0;
      in_nal_nxt = 1'b1;
      hist_nxt   = '0;
      hv_nxt     = '0;
    end else if (start_hit) begin
      if (in_nal_r) begin
        if (ends) begin
          idx_nxt = '0;
          ovf_nxt = 1'b0;
        end else if ({1'b0, idx_r} + 4'd1 >= MAX_NALS_W) begin
          ovf_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      hdr_nxt    = 1'b1;
      in_nal_nxt = 1'b0;
      count_nxt  = zeros + 24'd1;
      hist_nxt   = '0;
      hv_nxt     = '0;
    end else begin
      if (in_nal_r) count_nxt = sat_inc(count_r);
      hist_nxt = {hist_r[15:0], data_byte};
      if (hv_r != 2'd3) hv_nxt = hv_r + 2'd1;
    end
  end

  // state registers, updated on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '0;
      hv_r     <= '0;
      in_nal_r <= 1'b0;
      hdr_r    <= 1'b0;
      type_r   <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      ovf_r    <= 1'b0;
    end else if (step) begin
      hist_r   <= hist_nxt;
      hv_r     <= hv_nxt;
      in_nal_r <= in_nal_nxt;
      hdr_r    <= hdr_nxt;
      type_r   <= type_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

// ===== src/nalsp_out_stage.sv =====
// result register that holds one nal record until the sink takes it
// depends on nalsp_pkg
module nalsp_out_stage import nalsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  nal_rec_t  rec_in,
  input  logic      take,
  output logic      space,
  output logic      valid,
  output nal_rec_t  rec_out
);

  logic     valid_r;
  nal_rec_t rec_r;

  // room for a new record when empty or being drained this cycle
  assign space = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec_in;
    end
  end

  assign valid   = valid_r;
  assign rec_out = rec_r;

endmodule

// ===== src/annexb_nal_unit_splitter.sv =====
// top level of the annex b nal unit splitter
// depends on nalsp_pkg, nalsp_stream_if, nalsp_cfg_regs, nalsp_scanner, nalsp_out_stage
//
//  channel | dir | beat
//  --------+-----+---------------------------------------------------------
//  in_s    | in  | data_byte, one stream byte
//  out_m   | out | nal_type, nal_length, nal_index, unit_end, index_overflow
//  cfg_*   | in  | cfg_we, cfg_index, cfg_wdata (end type registers)
//
// one byte is taken per cycle while input ready is high; a record appears in the
// cycle after the byte that completes the next start code. the scanner state and
// the result register are the only storage on the path. reset is synchronous and
// clears all control state. outside reset, input ready drops only while a record
// waits in the result register and the sink holds out_m.ready low.
`include "annexb_nal_unit_splitter_defines.svh"

module annexb_nal_unit_splitter import nalsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  nalsp_in_if.sink         in_s,
  nalsp_out_if.source      out_m,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [5:0]       cfg_wdata
);

  end_types_t end_types;
  scan_res_t  scan;
  nal_rec_t   rec_q;
  logic       space;
  logic       step;
  logic       out_valid;

  assign in_s.ready = rst_n && space;
  assign step       = in_s.valid && in_s.ready;

  nalsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .end_types (end_types)
  );

  nalsp_scanner u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_s.data_byte),
    .end_types (end_types),
    .res       (scan)
  );

  nalsp_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step && scan.emit),
    .rec_in  (scan.rec),
    .take    (out_m.ready),
    .space   (space),
    .valid   (out_valid),
    .rec_out (rec_q)
  );

  // drive the result channel
  assign out_m.valid          = out_valid;
  assign out_m.nal_type       = rec_q.nal_type;
  assign out_m.nal_length     = rec_q.nal_length;
  assign out_m.nal_index      = rec_q.nal_index;
  assign out_m.unit_end       = rec_q.unit_end;
  assign out_m.index_overflow = rec_q.index_overflow;

  // checks
  `NALSP_ASSERT_NOW(a_stall_blocks_input, out_m.valid && !out_m.ready, !in_s.ready)
  `NALSP_ASSERT_NEXT(a_emit_reaches_output, step && scan.emit, out_m.valid)
  `NALSP_ASSERT_NOW(a_overflow_index, out_m.valid && out_m.index_overflow, out_m.nal_index == 3'(MAX_NALS - 1))

endmodule

// ===== tb/sv/nal_split_checker.sv =====
// record checker for the annex b nal unit splitter: predicts records from input beats
// and compares them with the output channel
// depends on nalsp_pkg and nalsp_stream_if
module nal_split_checker import nalsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  nalsp_in_if      in_mon,
  nalsp_out_if     out_mon,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  logic [5:0] cfg_wdata,
  output int       fail_count,
  output int       pending
);

  // predicted scanner state
  logic [23:0] hist;
  logic [1:0]  hist_n;
  logic        open_nal;
  logic        hdr_next;
  logic [5:0]  cur_type;
  logic [23:0] nal_bytes;
  logic [2:0]  au_index;
  logic        au_ovf;
  end_types_t  end_types;

  nal_rec_t pending_records[$];
  nal_rec_t got;
  nal_rec_t want;

  function automatic logic [23:0] bytes_plus_one(input logic [23:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 24'd1;
  endfunction

  // advance the splitter prediction by one stream byte
  task split_byte(input logic [7:0] b);
    logic [1:0] zeros;
    logic       closes_au;
    nal_rec_t   rec;
    if (hdr_next) begin
      // header byte: taken whatever its value, never part of a start code
      cur_type  = b[6:1];
      nal_bytes = bytes_plus_one(nal_bytes);
      hdr_next  = 1'b0;
      open_nal  = 1'b1;
      hist      = '0;
      hist_n    = '0;
    end else if (b == BYTE_ONE && hist_n >= 2'd2 && hist[15:0] == 16'h0000) begin
      zeros = (hist_n == 2'd3 && hist[23:16] == BYTE_ZERO) ? 2'd3 : 2'd2;
      if (open_nal) begin
        closes_au = (cur_type == end_types.first) || (cur_type == end_types.second);
        rec.nal_type = cur_type;
        if (nal_bytes == COUNT_MAX)
          rec.nal_length = COUNT_MAX;
        else if (nal_bytes >= 24'(zeros))
          rec.nal_length = nal_bytes - 24'(zeros);
        else
          rec.nal_length = '0;
        rec.nal_index      = au_index;
        rec.unit_end       = closes_au;
        rec.index_overflow = au_ovf;
        pending_records.push_back(rec);
        // access unit bookkeeping
        if (closes_au) begin
          au_index = '0;
          au_ovf   = 1'b0;
        end else if (int'(au_index) + 1 >= MAX_NALS) begin
          au_ovf = 1'b1;
        end else begin
          au_index = au_index + 3'd1;
        end
      end
      hdr_next  = 1'b1;
      open_nal  = 1'b0;
      nal_bytes = 24'(zeros) + 24'd1;
      hist      = '0;
      hist_n    = '0;
    end else begin
      if (open_nal)
        nal_bytes = bytes_plus_one(nal_bytes);
      hist = {hist[15:0], b};
      if (hist_n < 2'd3)
        hist_n = hist_n + 2'd1;
    end
  endtask

  // watch config writes, output beats and input beats at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      hist      = '0;
      hist_n    = '0;
      open_nal  = 1'b0;
      hdr_next  = 1'b0;
      cur_type  = '0;
      nal_bytes = '0;
      au_index  = '0;
      au_ovf    = 1'b0;
      end_types = '{first: END_FIRST_RST, second: END_SECOND_RST};
      pending_records.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_END_FIRST:  end_types.first  = cfg_wdata;
          CFG_END_SECOND: end_types.second = cfg_wdata;
          default: ;
        endcase
      end
      // compare an output beat with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.nal_type, out_mon.nal_length, out_mon.nal_index,
               out_mon.unit_end, out_mon.index_overflow};
        if (pending_records.size() == 0) begin
          $error("record with none expected: nal_type %0d nal_length %0d nal_index %0d",
                 got.nal_type, got.nal_length, got.nal_index);
          fail_count++;
        end else begin
          want = pending_records.pop_front();
          if (got.nal_type !== want.nal_type) begin
            $error("nal_type: expected %0d, got %0d", want.nal_type, got.nal_type);
            fail_count++;
          end
          if (got.nal_length !== want.nal_length) begin
            $error("nal_length: expected %0d, got %0d", want.nal_length, got.nal_length);
            fail_count++;
          end
          if (got.nal_index !== want.nal_index) begin
            $error("nal_index: expected %0d, got %0d", want.nal_index, got.nal_index);
            fail_count++;
          end
          if (got.unit_end !== want.unit_end) begin
            $error("unit_end: expected %0d, got %0d", want.unit_end, got.unit_end);
            fail_count++;
          end
          if (got.index_overflow !== want.index_overflow) begin
            $error("index_overflow: expected %0d, got %0d",
                   want.index_overflow, got.index_overflow);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        split_byte(in_mon.data_byte);
    end
    pending = pending_records.size();
  end

endmodule

// ===== tb/sv/annexb_nal_unit_splitter_tb.sv =====
// top of the annex b nal unit splitter testbench: clock, reset, byte stream stimulus,
// end type register writes, sink stalls and the verdict
// depends on nalsp_pkg, nalsp_stream_if, the splitter rtl and nal_split_checker
module annexb_nal_unit_splitter_tb;
  import nalsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 3;
  localparam int DIRECTED_LEN   = 26;

  // leading bytes, both start code lengths, odd header values, both end types
  localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
    8'hFF, 8'h00,
    8'h00, 8'h00, 8'h01, 8'hFF,
    8'h00, 8'h00, 8'h01, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h26,
    8'h55, 8'hAA,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h02,
    8'h00, 8'h00, 8'h01, 8'h00
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_idx_t   cfg_index;
  logic [5:0] cfg_wdata;

  int fail_count;
  int pending;
  int idle_cycles;
  int bytes_sent;
  int src_idle_pct;
  int snk_idle_pct;

  logic [5:0] ends_first;
  logic [5:0] ends_second;

  nalsp_in_if  in_ch();
  nalsp_out_if out_ch();

  annexb_nal_unit_splitter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_m     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nal_split_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink stalls
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input beat, with random source gaps; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // one well formed nal: start code, two header bytes, random body
  task automatic push_nal(input logic [5:0] nal_type);
    int body_len;
    int k;
    int pick;
    if ($urandom_range(1))
      push_byte(BYTE_ZERO);
    push_byte(BYTE_ZERO);
    push_byte(BYTE_ZERO);
    push_byte(BYTE_ONE);
    push_byte({1'($urandom_range(1)), nal_type, 1'($urandom_range(1))});
    push_byte(8'($urandom_range(255)));
    body_len = ($urandom_range(19) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    for (k = 0; k < body_len; k++) begin
      // zeros and ones are weighted up so near misses of a start code turn up
      pick = $urandom_range(15);
      if (pick < 3)
        push_byte(BYTE_ZERO);
      else if (pick == 3)
        push_byte(BYTE_ONE);
      else
        push_byte(8'($urandom_range(255)));
    end
  endtask

  // access units of one to eight nals, mostly closed by an end type, some noise
  task automatic run_stream(input int n_bytes);
    int target;
    int nals;
    int i;
    logic [5:0] t;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      nals = $urandom_range(1, 8);
      for (i = 0; i < nals; i++) begin
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0: begin push_byte(BYTE_ZERO); push_byte(BYTE_ONE); end
            1: begin push_byte(BYTE_ZERO); push_byte(BYTE_ZERO); push_byte(8'h02); end
            2: push_byte(8'($urandom_range(255)));
            default: begin push_byte(BYTE_ZERO); push_byte(BYTE_ZERO); end
          endcase
        end
        if (i == nals - 1) begin
          if ($urandom_range(9) == 0)
            t = 6'($urandom_range(63));
          else
            t = $urandom_range(1) ? ends_first : ends_second;
        end else begin
          do t = 6'($urandom_range(63)); while (t == ends_first || t == ends_second);
        end
        push_nal(t);
      end
    end
  endtask

  // drain every pending record, let the block settle, then write both end types
  task automatic set_end_types(input logic [5:0] first, input logic [5:0] second);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    ends_first  = first;
    ends_second = second;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_END_FIRST;
    cfg_wdata <= first;
    @(negedge clk);
    cfg_index <= CFG_END_SECOND;
    cfg_wdata <= second;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    logic [5:0] r;
    int k;
    src_idle_pct     = 6;
    snk_idle_pct     = 54;
    bytes_sent       = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_END_FIRST;
    cfg_wdata       <= '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, directed bytes, then random units
    set_end_types(END_FIRST_RST, END_SECOND_RST);
    for (k = 0; k < DIRECTED_LEN; k++)
      push_byte(DIRECTED_BYTES[k]);
    run_stream(300);
    set_end_types(6'd0, 6'd63);
    run_stream(350);

    // sender slow, receiver mostly ready
    src_idle_pct = 54;
    snk_idle_pct = 6;
    set_end_types(6'd63, 6'd0);
    run_stream(350);
    set_end_types(6'($urandom_range(63)), 6'($urandom_range(63)));
    run_stream(350);

    // no gaps on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    r = 6'($urandom_range(63));
    set_end_types(r, r);
    run_stream(350);

    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES + 1) @(negedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== annexb_nal_unit_splitter.f =====
+incdir+src
src/nalsp_pkg.sv
src/nalsp_stream_if.sv
src/nalsp_cfg_regs.sv
src/nalsp_scanner.sv
src/nalsp_out_stage.sv
src/annexb_nal_unit_splitter.sv
tb/sv/nal_split_checker.sv
tb/sv/annexb_nal_unit_splitter_tb.sv
